// File: src/drmt_pkg.sv
`default_nettype none
package drmt_pkg;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_MARK  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IGNORED = 2'd0,
		ST_STORED  = 2'd1,
		ST_WHOLE   = 2'd2,
		ST_READOUT = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [15:0] rect_left;
		logic signed [15:0] rect_top;
		logic signed [15:0] rect_width;
		logic signed [15:0] rect_height;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [12:0] out_left;
		logic [12:0] out_top;
		logic [12:0] out_width;
		logic [12:0] out_height;
		logic        rect_valid;
		logic        whole_screen;
		logic        dirty;
		logic [4:0]  entry_count;
		logic        last;
	} out_word_t;

	// classified command passed from front to back
	typedef struct packed {
		op_t         op;
		logic        drop;
		logic        full;
		logic [16:0] x0;
		logic [16:0] y0;
		logic [16:0] x1;
		logic [16:0] y1;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_SHIFT,
		BK_READ,
		BK_EMIT
	} bk_state_t;

	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

endpackage
`default_nettype wire

// File: src/drmt_front.sv
`default_nettype none
module drmt_front #(
	parameter int COORD_BITS = 13
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_vld,
	input  drmt_pkg::in_word_t in_word,
	input  wire [12:0]       frame_width,
	input  wire [12:0]       frame_height,
	output logic             cmd_vld,
	output drmt_pkg::cmd_t   cmd
);
	import drmt_pkg::*;

	localparam logic [12:0] CAP = 13'((1 << COORD_BITS) - 1);

	logic signed [17:0] x, y, w, h, fw, fh, cw, ch, xe, ye;
	cmd_t c;

	always_comb begin
		fw = (frame_width > CAP) ? 18'(CAP) : 18'(frame_width);
		fh = (frame_height > CAP) ? 18'(CAP) : 18'(frame_height);
		x = 18'(in_word.rect_left);
		y = 18'(in_word.rect_top);
		w = 18'(in_word.rect_width);
		h = 18'(in_word.rect_height);
		c = '0;
		c.op = op_t'(in_word.op);
		c.drop = (w <= 0) || (h <= 0);
		if (x < 0) begin
			w = w + x;
			x = '0;
		end
		if (y < 0) begin
			h = h + y;
			y = '0;
		end
		if (x >= fw || y >= fh) c.drop = 1'b1;
		cw = (x + w > fw) ? fw - x : w;
		ch = (y + h > fh) ? fh - y : h;
		if (cw <= 0 || ch <= 0) c.drop = 1'b1;
		xe = x + cw;
		ye = y + ch;
		c.full = (x == 0) && (y == 0) && (cw == fw) && (ch == fh);
		c.x0 = x[16:0];
		c.y0 = y[16:0];
		c.x1 = xe[16:0];
		c.y1 = ye[16:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_vld <= 1'b0;
		end else begin
			cmd_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) cmd <= c;
	end

endmodule
`default_nettype wire

// File: src/drmt_queue.sv
`default_nettype none
module drmt_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            wr_vld,
	input  drmt_pkg::cmd_t wr_cmd,
	input  wire            rd_en,
	output logic           rd_vld,
	output drmt_pkg::cmd_t rd_cmd,
	output logic           empty
);
	import drmt_pkg::*;

	cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign rd_vld = (cnt_q != 2'd0);
	assign empty = (cnt_q == 2'd0);
	assign rd_cmd = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr_vld) wp_q <= ~wp_q;
			if (rd_en && rd_vld) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_vld) - 2'(rd_en && rd_vld);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_vld) mem_q[wp_q] <= wr_cmd;
	end

endmodule
`default_nettype wire

// File: src/drmt_back.sv
`default_nettype none
module drmt_back #(
	parameter int LIST_DEPTH = 16
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cmd_vld,
	input  drmt_pkg::cmd_t   cmd,
	output logic             cmd_take,
	output logic             idle,
	output logic             res_vld,
	output drmt_pkg::out_word_t res
);
	import drmt_pkg::*;

	localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);

	bk_state_t st_q, st_d;
	logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, k_q, k_d;
	logic mark_q, mark_d, dirty_q, dirty_d;
	logic [16:0] x0_q, y0_q, x1_q, y1_q, x0_d, y0_d, x1_d, y1_d;
	logic [51:0] mem [LIST_DEPTH];
	logic [51:0] rd_q;
	logic [IW-1:0] ra;
	logic we;
	logic [IW-1:0] wa;
	logic [51:0] wd;
	logic rvld_d;
	out_word_t r_d;
	logic [16:0] bx0, by0, bx1, by1;
	logic hit;
	logic [12:0] ox0, oy0, ow, oh;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	always_comb begin
		bx0 = {4'd0, rd_q[51:39]};
		by0 = {4'd0, rd_q[38:26]};
		bx1 = bx0 + {4'd0, rd_q[25:13]};
		by1 = by0 + {4'd0, rd_q[12:0]};
		hit = (x0_q <= bx1) && (x1_q >= bx0) && (y0_q <= by1) && (y1_q >= by0);
		ox0 = x0_q[12:0];
		oy0 = y0_q[12:0];
		ow = 13'(x1_q - x0_q);
		oh = 13'(y1_q - y0_q);
	end

	always_comb begin
		st_d = st_q;
		cnt_d = cnt_q;
		i_d = i_q;
		k_d = k_q;
		mark_d = mark_q;
		dirty_d = dirty_q;
		x0_d = x0_q;
		y0_d = y0_q;
		x1_d = x1_q;
		y1_d = y1_q;
		cmd_take = 1'b0;
		we = 1'b0;
		wa = '0;
		wd = '0;
		ra = i_q[IW-1:0];
		rvld_d = 1'b0;
		r_d = '0;
		unique case (st_q)
			BK_IDLE: begin
				ra = '0;
				if (cmd_vld) begin
					cmd_take = 1'b1;
					rvld_d = 1'b1;
					r_d.last = 1'b1;
					x0_d = cmd.x0;
					y0_d = cmd.y0;
					x1_d = cmd.x1;
					y1_d = cmd.y1;
					i_d = '0;
					unique case (cmd.op)
						OP_MARK: begin
							mark_d = 1'b1;
							cnt_d = '0;
							dirty_d = 1'b1;
							r_d.status = ST_WHOLE;
						end
						OP_CLEAR: begin
							mark_d = 1'b0;
							cnt_d = '0;
							dirty_d = 1'b0;
							r_d.status = ST_IGNORED;
						end
						OP_READ: begin
							if (cnt_q == '0) begin
								r_d.status = ST_READOUT;
							end else begin
								rvld_d = 1'b0;
								st_d = BK_READ;
							end
						end
						default: begin
							if (mark_q || cmd.drop) begin
								r_d.status = ST_IGNORED;
							end else if (cmd.full) begin
								mark_d = 1'b1;
								cnt_d = '0;
								r_d.status = ST_WHOLE;
							end else begin
								rvld_d = 1'b0;
								st_d = BK_SCAN;
							end
						end
					endcase
					r_d.whole_screen = mark_d;
					r_d.dirty = dirty_d;
					r_d.entry_count = 5'(cnt_d);
				end
			end
			BK_READ: begin
				i_d = '0;
				ra = '0;
				st_d = BK_EMIT;
			end
			BK_EMIT: begin
				rvld_d = 1'b1;
				r_d.status = ST_READOUT;
				r_d.out_left = rd_q[51:39];
				r_d.out_top = rd_q[38:26];
				r_d.out_width = rd_q[25:13];
				r_d.out_height = rd_q[12:0];
				r_d.rect_valid = 1'b1;
				r_d.whole_screen = mark_q;
				r_d.dirty = dirty_q;
				r_d.entry_count = 5'(cnt_q);
				r_d.last = (i_q + 1'b1 == cnt_q);
				ra = IW'(i_q + 1'b1);
				if (i_q + 1'b1 == cnt_q) begin
					st_d = BK_IDLE;
				end else begin
					i_d = i_q + 1'b1;
				end
			end
			BK_SCAN: begin
				// rd_q holds entry i_q in the cycle after ra addresses it
				if (k_q == '0) begin
					k_d = CW'(1);
				end else if (i_q >= cnt_q) begin
					k_d = '0;
					rvld_d = 1'b1;
					r_d.last = 1'b1;
					st_d = BK_IDLE;
					if (cnt_q >= CW'(LIST_DEPTH)) begin
						mark_d = 1'b1;
						cnt_d = '0;
						r_d.status = ST_WHOLE;
					end else begin
						we = 1'b1;
						wa = IW'(cnt_q);
						wd = {ox0, oy0, ow, oh};
						cnt_d = cnt_q + 1'b1;
						dirty_d = 1'b1;
						r_d.status = ST_STORED;
					end
					r_d.whole_screen = mark_d;
					r_d.dirty = dirty_d;
					r_d.entry_count = 5'(cnt_d);
				end else if (hit) begin
					x0_d = (x0_q < bx0) ? x0_q : bx0;
					y0_d = (y0_q < by0) ? y0_q : by0;
					x1_d = (x1_q > bx1) ? x1_q : bx1;
					y1_d = (y1_q > by1) ? y1_q : by1;
					k_d = '0;
					ra = IW'(i_q + 1'b1);
					st_d = BK_SHIFT;
				end else begin
					i_d = i_q + 1'b1;
					k_d = '0;
					ra = IW'(i_d);
				end
			end
			BK_SHIFT: begin
				// rd_q = entry k+1 of the shift walk; k_q counts offset from i_q
				ra = IW'(i_q + k_q + 2'd2);
				if (CW'(i_q + k_q + 1'b1) < cnt_q) begin
					we = 1'b1;
					wa = IW'(i_q + k_q);
					wd = rd_q;
					k_d = k_q + 1'b1;
				end else begin
					cnt_d = cnt_q - 1'b1;
					k_d = '0;
					ra = IW'(i_q);
					st_d = BK_SCAN;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	assign idle = (st_q == BK_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			cnt_q <= '0;
			i_q <= '0;
			k_q <= '0;
			mark_q <= 1'b1;
			dirty_q <= 1'b0;
			res_vld <= 1'b0;
		end else begin
			st_q <= st_d;
			cnt_q <= cnt_d;
			i_q <= i_d;
			k_q <= k_d;
			mark_q <= mark_d;
			dirty_q <= dirty_d;
			res_vld <= rvld_d;
		end
	end

	always_ff @(posedge clk) begin
		x0_q <= x0_d;
		y0_q <= y0_d;
		x1_q <= x1_d;
		y1_q <= y1_d;
		res <= r_d;
	end

endmodule
`default_nettype wire

// File: src/damage_rect_merge_table.sv
// channel | handshake        | word
// in      | start / busy     | in_word (op, rectangle)
// out     | done             | out_word (status, rectangle, flags)
// cfg     | APB psel/penable | frame_width @0, frame_height @4
// Mark, clear, ignored add: the result passes the front register, the queue and the
// result register; busy holds until it is out, so one command is in flight at a time.
// An add scans every entry; an absorbed entry is merged in, later entries shift down
// over it and the scan resumes at that slot. Readout: one word per cycle.
// Reset clears the list; the whole-screen mark comes up set. No output stall.
`default_nettype none
module damage_rect_merge_table #(
	parameter int LIST_DEPTH = 16,
	parameter int COORD_BITS = 13
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  drmt_pkg::in_word_t    in_word,
	output logic                  done,
	output drmt_pkg::out_word_t   out_word,
	input  wire                   psel,
	input  wire                   penable,
	input  wire                   pwrite,
	input  wire  [2:0]            paddr,
	input  wire  [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import drmt_pkg::*;

	logic [12:0] fw_q, fh_q;
	logic acc, f_vld, q_vld, q_take, q_empty, b_idle;
	cmd_t f_cmd, q_cmd;
	logic busy_q;

	assign pready = 1'b1;
	assign acc = start && !busy;
	assign busy = busy_q;

	always_comb begin
		prdata = '0;
		unique case (paddr[2:1] == 2'd0 ? paddr[2] : 1'b1)
			1'b0: prdata = {19'd0, fw_q};
			default: prdata = {19'd0, fh_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 13'd1024;
			fh_q <= 13'd768;
			busy_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr[2] == REG_FRAME_WIDTH[0]) fw_q <= pwdata[12:0];
				else fh_q <= pwdata[12:0];
			end
			if (acc) busy_q <= 1'b1;
			else if (busy_q && !f_vld && q_empty && b_idle && !done && !q_take)
				busy_q <= 1'b0;
		end
	end

	drmt_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_vld(acc), .in_word(in_word),
		.frame_width(fw_q), .frame_height(fh_q), .cmd_vld(f_vld), .cmd(f_cmd)
	);

	drmt_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_vld(f_vld), .wr_cmd(f_cmd),
		.rd_en(q_take), .rd_vld(q_vld), .rd_cmd(q_cmd), .empty(q_empty)
	);

	drmt_back #(.LIST_DEPTH(LIST_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_vld(q_vld), .cmd(q_cmd),
		.cmd_take(q_take), .idle(b_idle), .res_vld(done), .res(out_word)
	);

endmodule
`default_nettype wire

// File: verif/damage_rect_merge_table_tb.sv
`default_nettype none
module damage_rect_merge_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import drmt_pkg::*;

	localparam int DEPTH = 16;
	localparam int CYCLE_LIMIT = 900000;

	class rect_list_predictor;
		int lft[DEPTH];
		int tp[DEPTH];
		int wd[DEPTH];
		int ht[DEPTH];
		int cnt;
		bit mark;
		bit redraw;
		int fw;
		int fh;
		out_word_t expected_words[$];
		int errors;

		function new();
			cnt = 0;
			mark = 1'b1;
			redraw = 1'b0;
			fw = 1024;
			fh = 768;
			errors = 0;
		endfunction

		function out_word_t word_for(status_t st, int idx, bit lst);
			out_word_t w;
			w = '0;
			w.status = st;
			if (idx >= 0) begin
				w.out_left = lft[idx][12:0];
				w.out_top = tp[idx][12:0];
				w.out_width = wd[idx][12:0];
				w.out_height = ht[idx][12:0];
				w.rect_valid = 1'b1;
			end
			w.whole_screen = mark;
			w.dirty = redraw;
			w.entry_count = cnt[4:0];
			w.last = lst;
			return w;
		endfunction

		function status_t merge_add(int x, int y, int w, int h);
			int i;
			int ax1, ay1, bx1, by1;
			int nx0, ny0, nx1, ny1;
			if (mark) return ST_IGNORED;
			if (w <= 0 || h <= 0) return ST_IGNORED;
			if (x < 0) begin
				w += x;
				x = 0;
			end
			if (y < 0) begin
				h += y;
				y = 0;
			end
			if (x >= fw || y >= fh) return ST_IGNORED;
			if (x + w > fw) w = fw - x;
			if (y + h > fh) h = fh - y;
			if (w <= 0 || h <= 0) return ST_IGNORED;
			if (x == 0 && y == 0 && w == fw && h == fh) begin
				mark = 1'b1;
				cnt = 0;
				return ST_WHOLE;
			end
			i = 0;
			while (i < cnt) begin
				ax1 = x + w;
				ay1 = y + h;
				bx1 = lft[i] + wd[i];
				by1 = tp[i] + ht[i];
				if (x <= bx1 && ax1 >= lft[i] && y <= by1 && ay1 >= tp[i]) begin
					nx0 = (x < lft[i]) ? x : lft[i];
					ny0 = (y < tp[i]) ? y : tp[i];
					nx1 = (ax1 > bx1) ? ax1 : bx1;
					ny1 = (ay1 > by1) ? ay1 : by1;
					x = nx0;
					y = ny0;
					w = nx1 - nx0;
					h = ny1 - ny0;
					for (int k = i; k + 1 < cnt; k++) begin
						lft[k] = lft[k+1];
						tp[k] = tp[k+1];
						wd[k] = wd[k+1];
						ht[k] = ht[k+1];
					end
					cnt--;
				end else begin
					i++;
				end
			end
			if (cnt >= DEPTH) begin
				mark = 1'b1;
				cnt = 0;
				return ST_WHOLE;
			end
			lft[cnt] = x;
			tp[cnt] = y;
			wd[cnt] = w;
			ht[cnt] = h;
			cnt++;
			redraw = 1'b1;
			return ST_STORED;
		endfunction

		function void note_input(in_word_t iw);
			status_t st;
			case (op_t'(iw.op))
				OP_READ: begin
					if (cnt == 0) begin
						expected_words.push_back(word_for(ST_READOUT, -1, 1'b1));
					end else begin
						for (int i = 0; i < cnt; i++)
							expected_words.push_back(word_for(ST_READOUT, i, i + 1 == cnt));
					end
					return;
				end
				OP_ADD: begin
					st = merge_add(int'(iw.rect_left), int'(iw.rect_top),
						int'(iw.rect_width), int'(iw.rect_height));
				end
				OP_MARK: begin
					mark = 1'b1;
					cnt = 0;
					redraw = 1'b1;
					st = ST_WHOLE;
				end
				default: begin
					mark = 1'b0;
					cnt = 0;
					redraw = 1'b0;
					st = ST_IGNORED;
				end
			endcase
			expected_words.push_back(word_for(st, -1, 1'b1));
		endfunction

		function void check_result(out_word_t act);
			out_word_t exp_w;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word %p", $time, act);
				errors++;
				return;
			end
			exp_w = expected_words.pop_front();
			if (act !== exp_w) begin
				$display("%0t: mismatch expected %p actual %p", $time, exp_w, act);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_word_t in_word;
	logic done;
	out_word_t out_word;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	rect_list_predictor sb = new();
	int cycles = 0;
	bit no_gaps = 1'b0;

	damage_rect_merge_table dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_word(in_word),
		.done(done), .out_word(out_word), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && done) sb.check_result(out_word);

	task automatic send(in_word_t w);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (busy);
		sb.note_input(w);
	endtask

	task automatic send_op(op_t op, int x, int y, int w, int h);
		in_word_t iw;
		iw.op = op;
		iw.rect_left = 16'(x);
		iw.rect_top = 16'(y);
		iw.rect_width = 16'(w);
		iw.rect_height = 16'(h);
		send(iw);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.expected_words.size() != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, int val);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 1'b0} << 1;
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_FRAME_WIDTH) sb.fw = val;
		else sb.fh = val;
		@(posedge clk);
	endtask

	task automatic random_item();
		in_word_t iw;
		int r;
		r = $urandom_range(0, 99);
		if (sb.mark && $urandom_range(0, 1)) begin
			send_op(OP_CLEAR, 0, 0, 0, 0);
		end else if (r < 8) begin
			iw = in_word_t'(66'({$urandom, $urandom, $urandom}));
			send(iw);
		end else if (r < 16) begin
			send_op(OP_READ, 0, 0, 0, 0);
		end else if (r < 19) begin
			send_op(OP_CLEAR, 0, 0, 0, 0);
		end else if (r < 21) begin
			send_op(OP_MARK, 0, 0, 0, 0);
		end else begin
			send_op(OP_ADD, $urandom_range(0, sb.fw + 8) - 8, $urandom_range(0, sb.fh + 8) - 8,
				$urandom_range(0, sb.fw / 6 + 10) - 1, $urandom_range(0, sb.fh / 6 + 10) - 1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		in_word = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(OP_ADD, 10, 10, 20, 20);
		send_op(OP_READ, 0, 0, 0, 0);
		send_op(OP_CLEAR, 0, 0, 0, 0);
		send_op(OP_READ, 0, 0, 0, 0);
		send_op(OP_ADD, 10, 10, 0, 5);
		send_op(OP_ADD, 10, 10, -32768, 5);
		send_op(OP_ADD, -32768, -32768, 32767, 32767);
		send_op(OP_ADD, 32767, 5, 10, 10);
		send_op(OP_ADD, -50, 5, 40, 10);
		send_op(OP_ADD, 100, 100, 10, 10);
		send_op(OP_ADD, 110, 105, 10, 10);
		send_op(OP_ADD, 300, 300, 5, 5);
		send_op(OP_ADD, 1000, 700, 100, 100);
		send_op(OP_READ, 0, 0, 0, 0);
		send_op(OP_ADD, 0, 0, 1024, 768);
		send_op(OP_READ, 0, 0, 0, 0);
		send_op(OP_CLEAR, 0, 0, 0, 0);
		for (int i = 0; i < DEPTH; i++) send_op(OP_ADD, i * 20, 0, 5, 5);
		send_op(OP_READ, 0, 0, 0, 0);
		send_op(OP_ADD, 400, 100, 5, 5);
		send_op(OP_MARK, 0, 0, 0, 0);
		send_op(OP_CLEAR, 0, 0, 0, 0);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					reg_write(REG_FRAME_WIDTH, 8191);
					reg_write(REG_FRAME_HEIGHT, 8191);
				end
				1: begin
					reg_write(REG_FRAME_WIDTH, 1);
					reg_write(REG_FRAME_HEIGHT, 1);
				end
				2: begin
					reg_write(REG_FRAME_WIDTH, $urandom_range(1, 8191));
					reg_write(REG_FRAME_HEIGHT, $urandom_range(1, 8191));
				end
				3: begin
					reg_write(REG_FRAME_WIDTH, 64);
					reg_write(REG_FRAME_HEIGHT, 48);
				end
				default: begin
					reg_write(REG_FRAME_WIDTH, 1024);
					reg_write(REG_FRAME_HEIGHT, 768);
				end
			endcase
			send_op(OP_CLEAR, 0, 0, 0, 0);
			for (int n = 0; n < 36; n++) begin
				if (n % 15 == 0) no_gaps = $urandom_range(0, 2) == 0;
				random_item();
			end
			no_gaps = 1'b0;
		end

		drain();
		repeat (350) @(posedge clk);
		if (sb.errors == 0 && sb.expected_words.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
src/drmt_pkg.sv
src/drmt_front.sv
src/drmt_queue.sv
src/drmt_back.sv
src/damage_rect_merge_table.sv
verif/damage_rect_merge_table_tb.sv
